// ----- design/fqa_pkg.sv -----
// shared widths, codes and types of the fastq per-column quality accumulator
package fqa_pkg;

  localparam int BYTE_W  = 8;
  localparam int COL_W   = 10;
  localparam int COLS_W  = 11;
  localparam int SUM_W   = 41;
  localparam int CNT_W   = 32;
  localparam int MEAN_W  = 17;
  localparam int DELTA_W = BYTE_W + 1;

  // restoring divider: one quotient bit beyond the mean width; the top two quotient bits flag overflow
  localparam int DIV_STEPS = MEAN_W + 1;
  localparam int REM_W     = SUM_W + 8;

  localparam logic               OP_STREAM    = 1'b0;
  localparam logic               OP_READ      = 1'b1;
  localparam logic [BYTE_W-1:0]  NEWLINE      = 8'd10;
  localparam logic [1:0]         QUAL_PHASE   = 2'd3;
  localparam logic [BYTE_W-1:0]  OFFSET_RESET = 8'd33;

  localparam logic [SUM_W-1:0]  SUM_MAX  = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0]  SUM_MIN  = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
  localparam logic [MEAN_W-1:0] MEAN_MAX = {1'b0, {(MEAN_W-1){1'b1}}};
  localparam logic [MEAN_W-1:0] MEAN_MIN = {1'b1, {(MEAN_W-1){1'b0}}};

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        cnt;
  } entry_t;

endpackage

// ----- design/fqa_if.sv -----
// valid/ready channels for input items and readout results
interface fqa_item_if;
  import fqa_pkg::*;

  logic              valid;
  logic              ready;
  logic              op;
  logic [BYTE_W-1:0] data_byte;
  logic [COL_W-1:0]  column_index;

  modport source (output valid, output op, output data_byte, output column_index,
                  input ready);
  modport sink (input valid, input op, input data_byte, input column_index,
                output ready);
endinterface

interface fqa_result_if;
  import fqa_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     column_valid;
  logic signed [SUM_W-1:0]  score_sum;
  logic [CNT_W-1:0]         read_count;
  logic signed [MEAN_W-1:0] mean_score_q8;
  logic [COLS_W-1:0]        columns_seen;
  logic                     overlong;

  modport source (output valid, output column_valid, output score_sum, output read_count,
                  output mean_score_q8, output columns_seen, output overlong,
                  input ready);
  modport sink (input valid, input column_valid, input score_sum, input read_count,
                input mean_score_q8, input columns_seen, input overlong,
                output ready);
endinterface

// ----- design/fastq_per_cycle_quality_accumulator_unit.sv -----
// fastq per-column quality accumulator: stream parser, column memory and readout divider
//
// Stream bytes are taken one per clock while no readout is in progress: each quality byte
// does a read-modify-write of its column entry in a single memory (read at the transfer,
// written in the following cycle, with the last write forwarded). A readout holds off the
// next transfer through a memory lookup state, 18 iterations of the restoring divider that
// form the Q.8 mean (one quotient bit per cycle) and a final state that loads the result
// register once it is free; a readout of a column with zero count skips the divider. The
// result register lets the next item in while a result waits. No clearing pass follows
// reset: an entry at or beyond the columns seen so far was never written and reads as zero.
module fastq_per_cycle_quality_accumulator_unit #(
  parameter int MAX_READ_LEN = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [fqa_pkg::BYTE_W-1:0] cfg_wr_data,
  fqa_item_if.sink                   item,
  fqa_result_if.source               result
);
  import fqa_pkg::*;

  localparam int AW     = (MAX_READ_LEN > 1) ? $clog2(MAX_READ_LEN) : 1;
  localparam int CW     = $clog2(MAX_READ_LEN + 1);
  localparam int STEP_W = $clog2(DIV_STEPS);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOOKUP = 2'd1;
  localparam logic [1:0] ST_DIV    = 2'd2;
  localparam logic [1:0] ST_FIN    = 2'd3;

  logic [1:0]        state;
  logic [BYTE_W-1:0] quality_offset;
  logic [1:0]        line_phase;
  logic [CW-1:0]     column_counter;
  logic [CW-1:0]     max_columns;
  logic              overlong_flag;

  entry_t            mem [0:MAX_READ_LEN-1];
  entry_t            mem_q;
  logic [AW-1:0]     rd_addr;

  logic              in_acc;
  logic              read_acc;
  logic              stream_acc;
  logic              col_fits;
  logic              qual_hit;

  logic [AW-1:0]             s1_addr;
  logic                      s1_fresh;
  logic                      wr_pend;
  logic signed [DELTA_W-1:0] wr_delta;
  logic                      wb_valid;
  logic [AW-1:0]             wb_addr;
  entry_t                    wb_data;
  entry_t                    cur_entry;
  entry_t                    wr_data;
  logic signed [SUM_W:0]     sum_wide;

  logic [REM_W-1:0]     div_rem;
  logic [REM_W-1:0]     div_dvs;
  logic [DIV_STEPS-1:0] div_q;
  logic [STEP_W-1:0]    div_step;
  logic [SUM_W-1:0]     lk_abs;
  logic                 q_big;
  logic [MEAN_W-1:0]    q_mag;
  logic [MEAN_W-1:0]    mean;

  logic                     res_neg;
  logic [SUM_W-1:0]         res_sum;
  logic [CNT_W-1:0]         res_cnt;
  logic                     res_col_valid;
  logic [COLS_W-1:0]        res_cols;
  logic                     res_overlong;

  logic                     out_valid;
  logic                     out_col_valid;
  logic [SUM_W-1:0]         out_sum;
  logic [CNT_W-1:0]         out_cnt;
  logic [MEAN_W-1:0]        out_mean;
  logic [COLS_W-1:0]        out_cols;
  logic                     out_overlong;

  assign item.ready  = (state == ST_IDLE);
  assign in_acc      = item.valid && item.ready;
  assign read_acc    = in_acc && (item.op == OP_READ);
  assign stream_acc  = in_acc && (item.op == OP_STREAM);
  assign col_fits    = (32'(column_counter) < MAX_READ_LEN);
  assign qual_hit    = stream_acc && (item.data_byte != NEWLINE) && (line_phase == QUAL_PHASE);

  assign rd_addr = (item.op == OP_READ) ? AW'(item.column_index) : AW'(column_counter);

  // column memory
  always_ff @(posedge clk) begin
    if (wr_pend) begin
      mem[s1_addr] <= wr_data;
    end
    mem_q <= mem[rd_addr];
  end

  // entry seen after the memory read: never-written entries read as zero, last write forwarded
  always_comb begin
    if (s1_fresh) begin
      cur_entry = '0;
    end else if (wb_valid && (wb_addr == s1_addr)) begin
      cur_entry = wb_data;
    end else begin
      cur_entry = mem_q;
    end
  end

  always_comb begin
    sum_wide = {cur_entry.sum[SUM_W-1], cur_entry.sum}
             + {{(SUM_W+1-DELTA_W){wr_delta[DELTA_W-1]}}, wr_delta};
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      wr_data.sum = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      wr_data.sum = sum_wide[SUM_W-1:0];
    end
    wr_data.cnt = (cur_entry.cnt == CNT_MAX) ? CNT_MAX : cur_entry.cnt + 1'b1;
  end

  assign lk_abs = cur_entry.sum[SUM_W-1] ? (~cur_entry.sum + 1'b1) : cur_entry.sum;

  assign q_big = div_q[DIV_STEPS-1] | div_q[DIV_STEPS-2];
  assign q_mag = div_q[MEAN_W-1:0];
  always_comb begin
    if (res_neg) begin
      mean = q_big ? MEAN_MIN : (~q_mag + 1'b1);
    end else begin
      mean = q_big ? MEAN_MAX : q_mag;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      quality_offset <= OFFSET_RESET;
      line_phase     <= '0;
      column_counter <= '0;
      max_columns    <= '0;
      overlong_flag  <= 1'b0;
      wr_pend        <= 1'b0;
      wb_valid       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        quality_offset <= cfg_wr_data;
      end
      wr_pend  <= qual_hit && col_fits;
      wb_valid <= wr_pend;
      if ((state == ST_FIN) && (!out_valid || result.ready)) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (stream_acc) begin
        if (item.data_byte == NEWLINE) begin
          line_phase     <= line_phase + 1'b1;
          column_counter <= '0;
        end else if (line_phase == QUAL_PHASE) begin
          if (!col_fits) begin
            overlong_flag <= 1'b1;
          end else begin
            column_counter <= column_counter + 1'b1;
            if (column_counter >= max_columns) begin
              max_columns <= column_counter + 1'b1;
            end
          end
        end
      end
      case (state)
        ST_IDLE: begin
          if (read_acc) begin
            state <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          state <= (cur_entry.cnt == '0) ? ST_FIN : ST_DIV;
        end
        ST_DIV: begin
          if (div_step == '0) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_valid || result.ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_addr  <= rd_addr;
      s1_fresh <= (item.op == OP_READ)
                ? !(32'(item.column_index) < 32'(max_columns))
                : (column_counter >= max_columns);
      wr_delta <= $signed({1'b0, item.data_byte}) - $signed({1'b0, quality_offset});
    end
    if (read_acc) begin
      res_col_valid <= (32'(item.column_index) < 32'(max_columns));
      res_cols      <= COLS_W'(max_columns);
      res_overlong  <= overlong_flag;
    end
    if (wr_pend) begin
      wb_addr <= s1_addr;
      wb_data <= wr_data;
    end
    case (state)
      ST_LOOKUP: begin
        res_sum  <= cur_entry.sum;
        res_cnt  <= cur_entry.cnt;
        res_neg  <= cur_entry.sum[SUM_W-1];
        div_rem  <= {lk_abs, 8'b0};
        div_dvs  <= {cur_entry.cnt, {(DIV_STEPS-1){1'b0}}};
        div_q    <= '0;
        div_step <= STEP_W'(DIV_STEPS - 1);
      end
      ST_DIV: begin
        if (div_rem >= div_dvs) begin
          div_rem <= div_rem - div_dvs;
          div_q   <= {div_q[DIV_STEPS-2:0], 1'b1};
        end else begin
          div_q   <= {div_q[DIV_STEPS-2:0], 1'b0};
        end
        div_dvs  <= div_dvs >> 1;
        div_step <= div_step - 1'b1;
      end
      ST_FIN: begin
        if (!out_valid || result.ready) begin
          out_col_valid <= res_col_valid;
          out_sum       <= res_sum;
          out_cnt       <= res_cnt;
          out_mean      <= mean;
          out_cols      <= res_cols;
          out_overlong  <= res_overlong;
        end
      end
      default: begin
      end
    endcase
  end

  assign result.valid         = out_valid;
  assign result.column_valid  = out_col_valid;
  assign result.score_sum     = out_sum;
  assign result.read_count    = out_cnt;
  assign result.mean_score_q8 = out_mean;
  assign result.columns_seen  = out_cols;
  assign result.overlong      = out_overlong;

  a_counter_within_seen: assert property (@(posedge clk) disable iff (rst)
    column_counter <= max_columns)
    else $error("column counter ahead of columns seen");

  a_seen_within_limit: assert property (@(posedge clk) disable iff (rst)
    32'(max_columns) <= MAX_READ_LEN)
    else $error("columns seen beyond memory depth");

  a_lookup_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOKUP) |-> !wr_pend)
    else $error("readout lookup overlaps a pending column write");

  a_read_starts_lookup: assert property (@(posedge clk) disable iff (rst)
    read_acc |=> (state == ST_LOOKUP))
    else $error("readout transfer did not start a lookup");

  a_write_forwarded: assert property (@(posedge clk) disable iff (rst)
    wr_pend |=> (wb_valid && (wb_addr == $past(s1_addr))))
    else $error("column write not captured for forwarding");

endmodule

// ----- test/testbench.sv -----
// testbench for the fastq per-column quality accumulator: column readouts checked against a predictor
module testbench;
  import fqa_pkg::*;

  localparam int LINE_LIMIT    = 1024;
  localparam int RANDOM_ITEMS  = 370;
  localparam int SETTLE_CYCLES = 30;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 1000000;

  localparam int IDLE_NONE   = 0;
  localparam int IDLE_SPARSE = 1;
  localparam int IDLE_FULL   = 2;

  localparam longint SUM_HI  = (longint'(1) << (SUM_W - 1)) - 1;
  localparam longint SUM_LO  = -(longint'(1) << (SUM_W - 1));
  localparam longint MEAN_HI = (longint'(1) << (MEAN_W - 1)) - 1;
  localparam longint MEAN_LO = -(longint'(1) << (MEAN_W - 1));

  typedef struct {
    logic                     column_valid;
    logic signed [SUM_W-1:0]  score_sum;
    logic [CNT_W-1:0]         read_count;
    logic signed [MEAN_W-1:0] mean_score_q8;
    logic [COLS_W-1:0]        columns_seen;
    logic                     overlong;
  } column_readout_t;

  logic              clk;
  logic              rst;
  logic              cfg_wr_en;
  logic [BYTE_W-1:0] cfg_wr_data;

  fqa_item_if   item_ch ();
  fqa_result_if result_ch ();

  fastq_per_cycle_quality_accumulator_unit #(.MAX_READ_LEN(LINE_LIMIT)) u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item        (item_ch),
    .result      (result_ch)
  );

  // predictor state
  logic [BYTE_W-1:0] qual_offset;
  logic [1:0]        line_ph;
  int                col_pos;
  int                widest;
  logic              long_line;
  longint            col_sum [LINE_LIMIT];
  int unsigned       col_cnt [LINE_LIMIT];

  column_readout_t pending_readouts [$];

  int  sender_mode;
  int  taker_mode;
  bit  hold_request;
  int  fail_count;
  int  stream_count;
  int  readout_count;
  int  compared_count;
  int  cycle_count;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int draw_gap(int mode);
    case (mode)
      IDLE_NONE:   return 0;
      IDLE_SPARSE: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 11) : 0;
      default:     return $urandom_range(0, 11);
    endcase
  endfunction

  function automatic void accumulate_item(logic op, logic [BYTE_W-1:0] data,
                                          logic [COL_W-1:0] col);
    longint          acc;
    longint          mean;
    int unsigned     cnt;
    column_readout_t want;
    if (op == OP_STREAM) begin
      stream_count++;
      if (data == NEWLINE) begin
        line_ph = line_ph + 2'd1;
        col_pos = 0;
      end else if (line_ph == QUAL_PHASE) begin
        if (col_pos >= LINE_LIMIT) begin
          long_line = 1'b1;
        end else begin
          acc = col_sum[col_pos] + longint'(data) - longint'(qual_offset);
          if (acc > SUM_HI) acc = SUM_HI;
          if (acc < SUM_LO) acc = SUM_LO;
          col_sum[col_pos] = acc;
          if (col_cnt[col_pos] != CNT_MAX) col_cnt[col_pos]++;
          col_pos++;
          if (col_pos > widest) widest = col_pos;
        end
      end
    end else begin
      readout_count++;
      acc  = col_sum[col];
      cnt  = col_cnt[col];
      mean = 0;
      if (cnt != 0) begin
        mean = (acc * 256) / longint'(cnt);
        if (mean > MEAN_HI) mean = MEAN_HI;
        if (mean < MEAN_LO) mean = MEAN_LO;
      end
      want.column_valid  = (int'(col) < widest);
      want.score_sum     = SUM_W'(acc);
      want.read_count    = cnt;
      want.mean_score_q8 = MEAN_W'(mean);
      want.columns_seen  = COLS_W'(widest);
      want.overlong      = long_line;
      pending_readouts.push_back(want);
    end
  endfunction

  task automatic send_item(input logic op, input logic [BYTE_W-1:0] data,
                           input logic [COL_W-1:0] col);
    int gap;
    gap = draw_gap(sender_mode);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid        <= 1'b1;
    item_ch.op           <= op;
    item_ch.data_byte    <= data;
    item_ch.column_index <= col;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    accumulate_item(op, data, col);
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] data);
    send_item(OP_STREAM, data, COL_W'($urandom_range(0, LINE_LIMIT - 1)));
  endtask

  task automatic send_read(input int col);
    send_item(OP_READ, BYTE_W'($urandom_range(0, 255)), COL_W'(col));
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [BYTE_W-1:0] qual_byte(bit wide_range);
    logic [BYTE_W-1:0] b;
    if (!wide_range) return BYTE_W'($urandom_range(33, 74));
    do b = BYTE_W'($urandom_range(0, 255)); while (b == NEWLINE);
    return b;
  endfunction

  task automatic send_record(input int len, input bit wide_range);
    string bases;
    bases = "ACGTN";
    send_byte("@");
    repeat ($urandom_range(0, 5)) send_byte(BYTE_W'($urandom_range(33, 126)));
    send_byte(NEWLINE);
    repeat (len) send_byte(bases[$urandom_range(0, 4)]);
    send_byte(NEWLINE);
    send_text("+\n");
    repeat (len) send_byte(qual_byte(wide_range));
    send_byte(NEWLINE);
  endtask

  task automatic realign_lines();
    while (line_ph != 2'd0) send_byte(NEWLINE);
  endtask

  task automatic drain_results();
    item_ch.valid <= 1'b0;
    while (pending_readouts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_offset(input logic [BYTE_W-1:0] value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    qual_offset = value;
  endtask

  // result side: per-result stall, or one long hold on request
  initial begin : result_taker
    int stall;
    result_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        stall = HOLD_CYCLES;
      end else begin
        stall = draw_gap(taker_mode);
      end
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!result_ch.valid && !hold_request) @(posedge clk);
    end
  end

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    column_readout_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_readouts.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected readout transfer, expected none, actual score_sum %0d",
                 $time, result_ch.score_sum);
      end else begin
        want = pending_readouts.pop_front();
        compared_count++;
        check_field("column_valid", want.column_valid, result_ch.column_valid);
        check_field("score_sum", want.score_sum, result_ch.score_sum);
        check_field("read_count", want.read_count, result_ch.read_count);
        check_field("mean_score_q8", want.mean_score_q8, result_ch.mean_score_q8);
        check_field("columns_seen", want.columns_seen, result_ch.columns_seen);
        check_field("overlong", want.overlong, result_ch.overlong);
      end
    end
  end

  task automatic test_directed_columns();
    logic [BYTE_W-1:0] extreme_bytes [6];
    extreme_bytes = '{8'h00, 8'hFF, 8'h0D, 8'h80, 8'h7F, OFFSET_RESET};
    send_read(0);
    send_read(LINE_LIMIT - 1);
    send_text("@d");
    send_byte(8'hFF);
    send_text("\nACGTN\n+\n");
    foreach (extreme_bytes[i]) send_byte(extreme_bytes[i]);
    send_byte(NEWLINE);
    for (int c = 0; c < 8; c++) send_read(c);
  endtask

  task automatic test_offset_extremes();
    set_offset(8'h00);
    send_text("@a\nAC\n+\n");
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(NEWLINE);
    send_read(0);
    send_read(1);
    set_offset(8'hFF);
    send_text("@b\nAC\n+\n");
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(NEWLINE);
    send_read(0);
    send_read(1);
    set_offset(OFFSET_RESET);
  endtask

  task automatic test_random_records();
    int base;
    int counted;
    int len;
    int next_cfg;
    int cfg_step;
    base     = stream_count + readout_count;
    counted  = 0;
    next_cfg = 100;
    cfg_step = 0;
    while (counted < RANDOM_ITEMS) begin
      if ($urandom_range(0, 7) == 0) begin
        sender_mode = $urandom_range(IDLE_NONE, IDLE_FULL);
        taker_mode  = $urandom_range(IDLE_NONE, IDLE_FULL);
      end
      if ($urandom_range(0, 9) == 0) begin
        // broken record: raw bytes with stray newlines
        len = $urandom_range(1, 12);
        repeat (len) send_byte(($urandom_range(0, 3) == 0) ? NEWLINE
                                                           : BYTE_W'($urandom_range(0, 255)));
        realign_lines();
      end else begin
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(31, 80) : $urandom_range(1, 30);
        send_record(len, $urandom_range(0, 1));
      end
      repeat ($urandom_range(0, 4)) begin
        send_read(($urandom_range(0, 3) == 0) ? $urandom_range(0, LINE_LIMIT - 1)
                                              : $urandom_range(0, widest + 2));
      end
      counted = stream_count + readout_count - base;
      if (counted >= next_cfg) begin
        case (cfg_step % 4)
          0: set_offset(BYTE_W'($urandom_range(0, 255)));
          1: set_offset(8'h00);
          2: set_offset(8'hFF);
          default: set_offset(OFFSET_RESET);
        endcase
        cfg_step++;
        next_cfg += 100;
      end
    end
    drain_results();
  endtask

  task automatic test_result_stall();
    sender_mode  = IDLE_NONE;
    taker_mode   = IDLE_NONE;
    hold_request = 1'b1;
    repeat (6) begin
      send_record($urandom_range(4, 12), 1'b0);
      repeat (4) send_read($urandom_range(0, 15));
    end
    drain_results();
  endtask

  task automatic test_overlong_line();
    sender_mode = IDLE_NONE;
    taker_mode  = IDLE_SPARSE;
    set_offset(BYTE_W'($urandom_range(0, 255)));
    realign_lines();
    send_text("@long\nA\n+\n");
    repeat (LINE_LIMIT + 6) send_byte(qual_byte(1'b1));
    send_byte(NEWLINE);
    send_read(LINE_LIMIT - 1);
    send_read(0);
    send_read($urandom_range(0, LINE_LIMIT - 1));
    sender_mode = IDLE_FULL;
    taker_mode  = IDLE_FULL;
    send_record(3, 1'b0);
    send_read(LINE_LIMIT - 1);
    send_read(2);
  endtask

  initial begin
    rst                  = 1'b1;
    cfg_wr_en            = 1'b0;
    cfg_wr_data          = '0;
    item_ch.valid        = 1'b0;
    item_ch.op           = OP_STREAM;
    item_ch.data_byte    = '0;
    item_ch.column_index = '0;
    sender_mode          = IDLE_FULL;
    taker_mode           = IDLE_FULL;
    hold_request         = 1'b0;
    fail_count           = 0;
    stream_count         = 0;
    readout_count        = 0;
    compared_count       = 0;
    cycle_count          = 0;
    qual_offset          = OFFSET_RESET;
    line_ph              = 2'd0;
    col_pos              = 0;
    widest               = 0;
    long_line            = 1'b0;
    foreach (col_sum[i]) begin
      col_sum[i] = 0;
      col_cnt[i] = 0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed_columns();
    test_offset_extremes();
    test_random_records();
    test_result_stall();
    test_overlong_line();
    drain_results();
    $display("stream bytes %0d, readouts %0d, results compared %0d",
             stream_count, readout_count, compared_count);
    $display("offsets 0, 33, 255 and random; long result hold; quality line past the limit");
    if (fail_count == 0 && pending_readouts.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
